[hw/rtl/dccl_pkg.sv]
// Shared types, kind codes and corner tables for the dual cell classifier.
`timescale 1ns / 1ps

package dccl_pkg;

	// Width of one key field on the ports
	localparam int KEY_W = 32;

	// Cell kind codes
	localparam logic [2:0] K_DROP  = 3'd0;
	localparam logic [2:0] K_CUBE  = 3'd1;
	localparam logic [2:0] K_HEX   = 3'd2;
	localparam logic [2:0] K_PYR   = 3'd3;
	localparam logic [2:0] K_TET   = 3'd4;
	localparam logic [2:0] K_WEDGE = 3'd5;
	localparam logic [2:0] K_ERR   = 3'd6;

	// Collapsed faces: four face corners, pyramid base (four), pyramid top
	localparam logic [2:0] FACE_TAB [6][9] = '{
		'{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd7, 3'd6, 3'd5, 3'd0},
		'{3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4},
		'{3'd0, 3'd1, 3'd4, 3'd5, 3'd2, 3'd6, 3'd7, 3'd3, 3'd0},
		'{3'd2, 3'd3, 3'd6, 3'd7, 3'd0, 3'd4, 3'd5, 3'd1, 3'd2},
		'{3'd0, 3'd3, 3'd4, 3'd7, 3'd1, 3'd5, 3'd6, 3'd2, 3'd0},
		'{3'd1, 3'd2, 3'd5, 3'd6, 3'd0, 3'd3, 3'd7, 3'd4, 3'd1}
	};

	// Collapsed edge pairs (a,b),(c,d), then front and back triangles
	localparam logic [2:0] WEDGE_TAB [12][10] = '{
		'{3'd0, 3'd1, 3'd4, 3'd5, 3'd3, 3'd2, 3'd0, 3'd7, 3'd6, 3'd4},
		'{3'd0, 3'd4, 3'd1, 3'd5, 3'd2, 3'd6, 3'd5, 3'd3, 3'd7, 3'd4},
		'{3'd3, 3'd7, 3'd2, 3'd6, 3'd5, 3'd1, 3'd2, 3'd4, 3'd0, 3'd3},
		'{3'd2, 3'd3, 3'd6, 3'd7, 3'd1, 3'd0, 3'd3, 3'd5, 3'd4, 3'd7},
		'{3'd4, 3'd7, 3'd5, 3'd6, 3'd3, 3'd0, 3'd4, 3'd2, 3'd1, 3'd6},
		'{3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd1, 3'd4, 3'd3, 3'd2, 3'd7},
		'{3'd0, 3'd1, 3'd3, 3'd2, 3'd5, 3'd4, 3'd0, 3'd6, 3'd7, 3'd3},
		'{3'd0, 3'd3, 3'd1, 3'd2, 3'd4, 3'd7, 3'd3, 3'd5, 3'd6, 3'd2},
		'{3'd0, 3'd3, 3'd4, 3'd7, 3'd5, 3'd6, 3'd7, 3'd1, 3'd2, 3'd3},
		'{3'd0, 3'd4, 3'd3, 3'd7, 3'd1, 3'd5, 3'd4, 3'd2, 3'd6, 3'd7},
		'{3'd1, 3'd2, 3'd5, 3'd6, 3'd7, 3'd4, 3'd5, 3'd3, 3'd0, 3'd1},
		'{3'd1, 3'd5, 3'd2, 3'd6, 3'd4, 3'd0, 3'd1, 3'd7, 3'd3, 3'd2}
	};

	// Pairwise key equality, [i][j] set when key i equals key j
	typedef logic [7:0][7:0] eq_t;

	// Output corner list, entry n is the input corner for output vertex n
	typedef logic [7:0][2:0] corners_t;

	// Input item
	typedef struct packed {
		logic [KEY_W-1:0] key0;
		logic [KEY_W-1:0] key1;
		logic [KEY_W-1:0] key2;
		logic [KEY_W-1:0] key3;
		logic [KEY_W-1:0] key4;
		logic [KEY_W-1:0] key5;
		logic [KEY_W-1:0] key6;
		logic [KEY_W-1:0] key7;
		logic             levels_equal;
		logic [4:0]       cell_level;
	} in_t;

	// Result item
	typedef struct packed {
		logic [2:0] kind;
		logic [2:0] out_corner0;
		logic [2:0] out_corner1;
		logic [2:0] out_corner2;
		logic [2:0] out_corner3;
		logic [2:0] out_corner4;
		logic [2:0] out_corner5;
		logic [2:0] out_corner6;
		logic [2:0] out_corner7;
		logic [4:0] out_level;
	} out_t;

endpackage

[hw/rtl/dccl_cmp.sv]
// Pairwise equality matrix over the eight corner keys.
`timescale 1ns / 1ps

module dccl_cmp #(
	parameter int W = 32
) (
	input  logic [7:0][W-1:0] keys,
	output dccl_pkg::eq_t     eq
);
	import dccl_pkg::*;

	// Upper triangle compares, mirrored below, diagonal set
	always_comb begin
		eq = '0;
		for (int i = 0; i < 8; i++) begin
			eq[i][i] = 1'b1;
			for (int j = i + 1; j < 8; j++) begin
				eq[i][j] = (keys[i] == keys[j]);
				eq[j][i] = eq[i][j];
			end
		end
	end

endmodule

[hw/rtl/dccl_classify.sv]
// Distinct key count and cell kind selection from the equality matrix.
`timescale 1ns / 1ps

module dccl_classify (
	input  dccl_pkg::eq_t  eq,
	input  logic           levels_equal,
	input  logic [4:0]     cell_level,
	output dccl_pkg::out_t verdict
);
	import dccl_pkg::*;

	logic [7:0]  fresh;
	logic [3:0]  uniq;
	logic [5:0]  face_hit;
	logic [5:0]  face_first;
	logic [11:0] wedge_hit;
	logic [11:0] wedge_first;
	logic [2:0]  face_kind [6];
	corners_t    face_crn [6];
	logic [2:0]  kind;
	corners_t    crn;
	corners_t    ident;
	logic [4:0]  level;

	// A key is fresh when no earlier corner carries it
	always_comb begin
		uniq = '0;
		for (int i = 0; i < 8; i++) begin
			fresh[i] = 1'b1;
			for (int j = 0; j < i; j++) begin
				if (eq[j][i]) begin
					fresh[i] = 1'b0;
				end
			end
			uniq = uniq + 4'(fresh[i]);
		end
	end

	// Per face: collapse test and the pyramid / tet / drop / error outcome
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			face_hit[i] = eq[FACE_TAB[i][0]][FACE_TAB[i][1]]
				&& eq[FACE_TAB[i][0]][FACE_TAB[i][2]]
				&& eq[FACE_TAB[i][0]][FACE_TAB[i][3]];
			face_kind[i] = K_ERR;
			face_crn[i] = '0;
			if (uniq == 4'd5) begin
				face_kind[i] = K_PYR;
				face_crn[i][0] = FACE_TAB[i][4];
				face_crn[i][1] = FACE_TAB[i][5];
				face_crn[i][2] = FACE_TAB[i][6];
				face_crn[i][3] = FACE_TAB[i][7];
				face_crn[i][4] = FACE_TAB[i][8];
			end else if (uniq == 4'd4) begin
				face_crn[i][3] = FACE_TAB[i][8];
				if (eq[FACE_TAB[i][4]][FACE_TAB[i][5]]) begin
					face_kind[i] = K_TET;
					face_crn[i][0] = FACE_TAB[i][5];
					face_crn[i][1] = FACE_TAB[i][6];
					face_crn[i][2] = FACE_TAB[i][7];
				end else if (eq[FACE_TAB[i][5]][FACE_TAB[i][6]]) begin
					face_kind[i] = K_TET;
					face_crn[i][0] = FACE_TAB[i][6];
					face_crn[i][1] = FACE_TAB[i][7];
					face_crn[i][2] = FACE_TAB[i][4];
				end else if (eq[FACE_TAB[i][6]][FACE_TAB[i][7]]) begin
					face_kind[i] = K_TET;
					face_crn[i][0] = FACE_TAB[i][7];
					face_crn[i][1] = FACE_TAB[i][4];
					face_crn[i][2] = FACE_TAB[i][5];
				end else if (eq[FACE_TAB[i][7]][FACE_TAB[i][4]]) begin
					face_kind[i] = K_TET;
					face_crn[i][0] = FACE_TAB[i][4];
					face_crn[i][1] = FACE_TAB[i][5];
					face_crn[i][2] = FACE_TAB[i][6];
				end else if (eq[FACE_TAB[i][4]][FACE_TAB[i][6]]
						|| eq[FACE_TAB[i][5]][FACE_TAB[i][7]]) begin
					face_kind[i] = K_DROP;
					face_crn[i] = '0;
				end else begin
					face_crn[i] = '0;
				end
			end
		end
		face_first = face_hit & (~face_hit + 6'd1);
	end

	// Edge pair collapse tests, lowest entry wins
	always_comb begin
		for (int i = 0; i < 12; i++) begin
			wedge_hit[i] = eq[WEDGE_TAB[i][0]][WEDGE_TAB[i][1]]
				&& eq[WEDGE_TAB[i][2]][WEDGE_TAB[i][3]];
		end
		wedge_first = wedge_hit & (~wedge_hit + 12'd1);
	end

	// Final selection in check order
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			ident[i] = 3'(i);
		end
		kind = K_HEX;
		crn = '0;
		level = '0;
		if (levels_equal || uniq == 4'd8) begin
			kind = levels_equal ? K_CUBE : K_HEX;
			crn = ident;
			level = levels_equal ? cell_level : 5'd0;
		end else if (uniq < 4'd4) begin
			kind = K_DROP;
		end else if (|face_hit) begin
			kind = '0;
			for (int i = 0; i < 6; i++) begin
				if (face_first[i]) begin
					kind = kind | face_kind[i];
					crn = crn | face_crn[i];
				end
			end
		end else if (|wedge_hit) begin
			kind = K_WEDGE;
			for (int i = 0; i < 12; i++) begin
				if (wedge_first[i]) begin
					for (int j = 0; j < 6; j++) begin
						crn[j] = crn[j] | WEDGE_TAB[i][4 + j];
					end
				end
			end
		end else begin
			crn = ident;
		end
	end

	// Pack the result
	always_comb begin
		verdict.kind = kind;
		verdict.out_corner0 = crn[0];
		verdict.out_corner1 = crn[1];
		verdict.out_corner2 = crn[2];
		verdict.out_corner3 = crn[3];
		verdict.out_corner4 = crn[4];
		verdict.out_corner5 = crn[5];
		verdict.out_corner6 = crn[6];
		verdict.out_corner7 = crn[7];
		verdict.out_level = level;
	end

endmodule

[hw/rtl/dual_cell_degeneracy_classifier_top.sv]
// Top level of the dual cell degeneracy classifier: registers and handshake.
`timescale 1ns / 1ps

// Channel   Ports              Transfer when
// input     start, dual        start high and busy low at a rising edge
// result    done, verdict      done high, one cycle, receiver cannot stall
//
// One cell per cycle; each accepted cell passes the input register, the registered
// key equality matrix and the result register, in that order, to the done strobe.
// The comparator bank (28 key compares) fills the second stage, the distinct
// count and priority selection the third. busy is always low.
// arst_n clears the stage valid bits and the done strobe; payload is unreset.
module dual_cell_degeneracy_classifier_top #(
	parameter int KEY_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  dccl_pkg::in_t  dual,
	output logic           done,
	output dccl_pkg::out_t verdict
);
	import dccl_pkg::*;

	localparam int CMP_BITS = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

	logic                    valid_s1;
	logic [7:0][CMP_BITS-1:0] keys_s1;
	logic                    lev_eq_s1;
	logic [4:0]              level_s1;

	eq_t                     eq_c;
	logic                    valid_s2;
	eq_t                     eq_s2;
	logic                    lev_eq_s2;
	logic [4:0]              level_s2;

	out_t                    verdict_c;
	logic                    done_q;
	out_t                    verdict_q;

	logic                    take;

	assign busy = 1'b0;
	assign take = start && !busy;

	// Stage 1: capture keys on their compared bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			keys_s1[0] <= dual.key0[CMP_BITS-1:0];
			keys_s1[1] <= dual.key1[CMP_BITS-1:0];
			keys_s1[2] <= dual.key2[CMP_BITS-1:0];
			keys_s1[3] <= dual.key3[CMP_BITS-1:0];
			keys_s1[4] <= dual.key4[CMP_BITS-1:0];
			keys_s1[5] <= dual.key5[CMP_BITS-1:0];
			keys_s1[6] <= dual.key6[CMP_BITS-1:0];
			keys_s1[7] <= dual.key7[CMP_BITS-1:0];
			lev_eq_s1 <= dual.levels_equal;
			level_s1 <= dual.cell_level;
		end
	end

	// Stage 2: equality matrix
	dccl_cmp #(
		.W(CMP_BITS)
	) u_cmp (
		.keys(keys_s1),
		.eq(eq_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			eq_s2 <= eq_c;
			lev_eq_s2 <= lev_eq_s1;
			level_s2 <= level_s1;
		end
	end

	// Stage 3: classification into the result register
	dccl_classify u_classify (
		.eq(eq_s2),
		.levels_equal(lev_eq_s2),
		.cell_level(level_s2),
		.verdict(verdict_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			verdict_q <= verdict_c;
		end
	end

	assign done = done_q;
	assign verdict = verdict_q;

	// Every accepted cell yields its result strobe
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##3 done)
	else $error("accepted cell produced no result strobe");

	// No strobe without a cell in flight
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s2))
	else $error("result strobe without a cell in flight");

	// Only a perfect cube carries a level
	a_level_cube: assert property (@(posedge clk) disable iff (!arst_n)
		(done && verdict.out_level != 5'd0) |-> verdict.kind == K_CUBE)
	else $error("level reported for a cell that is not a perfect cube");

	// Dropped and error cells carry no corners
	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (verdict.kind == K_DROP || verdict.kind == K_ERR))
		|-> (verdict.out_corner0 == 3'd0 && verdict.out_corner1 == 3'd0
			&& verdict.out_corner2 == 3'd0 && verdict.out_corner3 == 3'd0
			&& verdict.out_corner4 == 3'd0 && verdict.out_corner5 == 3'd0
			&& verdict.out_corner6 == 3'd0 && verdict.out_corner7 == 3'd0))
	else $error("dropped or error cell reports corners");

endmodule

[tb/dccl_verdict_checker.sv]
// Checker for the dual cell classifier: predicts each cell's verdict and compares results.
`timescale 1ns / 1ps

module dccl_verdict_checker
	import dccl_pkg::*;
#(
	parameter int KEY_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  in_t  dual,
	input  logic done,
	input  out_t verdict,
	output int   mismatches,
	output int   awaiting
);

	// Corner sets of the six faces: face corners, pyramid base in ring order, apex
	localparam logic [2:0] FACE_CORNERS [6][9] = '{
		'{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd7, 3'd6, 3'd5, 3'd0},
		'{3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4},
		'{3'd0, 3'd1, 3'd4, 3'd5, 3'd2, 3'd6, 3'd7, 3'd3, 3'd0},
		'{3'd2, 3'd3, 3'd6, 3'd7, 3'd0, 3'd4, 3'd5, 3'd1, 3'd2},
		'{3'd0, 3'd3, 3'd4, 3'd7, 3'd1, 3'd5, 3'd6, 3'd2, 3'd0},
		'{3'd1, 3'd2, 3'd5, 3'd6, 3'd0, 3'd3, 3'd7, 3'd4, 3'd1}
	};

	// Edge pairs in priority order: edge (a,b), edge (c,d), front and back triangles
	localparam logic [2:0] EDGE_PAIRS [12][10] = '{
		'{3'd0, 3'd1, 3'd4, 3'd5, 3'd3, 3'd2, 3'd0, 3'd7, 3'd6, 3'd4},
		'{3'd0, 3'd4, 3'd1, 3'd5, 3'd2, 3'd6, 3'd5, 3'd3, 3'd7, 3'd4},
		'{3'd3, 3'd7, 3'd2, 3'd6, 3'd5, 3'd1, 3'd2, 3'd4, 3'd0, 3'd3},
		'{3'd2, 3'd3, 3'd6, 3'd7, 3'd1, 3'd0, 3'd3, 3'd5, 3'd4, 3'd7},
		'{3'd4, 3'd7, 3'd5, 3'd6, 3'd3, 3'd0, 3'd4, 3'd2, 3'd1, 3'd6},
		'{3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd1, 3'd4, 3'd3, 3'd2, 3'd7},
		'{3'd0, 3'd1, 3'd3, 3'd2, 3'd5, 3'd4, 3'd0, 3'd6, 3'd7, 3'd3},
		'{3'd0, 3'd3, 3'd1, 3'd2, 3'd4, 3'd7, 3'd3, 3'd5, 3'd6, 3'd2},
		'{3'd0, 3'd3, 3'd4, 3'd7, 3'd5, 3'd6, 3'd7, 3'd1, 3'd2, 3'd3},
		'{3'd0, 3'd4, 3'd3, 3'd7, 3'd1, 3'd5, 3'd4, 3'd2, 3'd6, 3'd7},
		'{3'd1, 3'd2, 3'd5, 3'd6, 3'd7, 3'd4, 3'd5, 3'd3, 3'd0, 3'd1},
		'{3'd1, 3'd5, 3'd2, 3'd6, 3'd4, 3'd0, 3'd1, 3'd7, 3'd3, 3'd2}
	};

	localparam logic [31:0] KEY_MASK =
		(KEY_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << KEY_BITS) - 32'd1);

	out_t verdict_q [$];
	int   err_cnt = 0;
	int   pend    = 0;

	// Expected verdict of one dual cell
	function automatic out_t predict_verdict(in_t item);
		logic [31:0] k [8];
		logic [2:0]  c [8];
		logic [2:0]  kind;
		logic [2:0]  b0, b1, b2, b3, apex;
		int          distinct;
		bit          fresh;
		bit          matched;
		out_t        res;
		k[0] = item.key0 & KEY_MASK;
		k[1] = item.key1 & KEY_MASK;
		k[2] = item.key2 & KEY_MASK;
		k[3] = item.key3 & KEY_MASK;
		k[4] = item.key4 & KEY_MASK;
		k[5] = item.key5 & KEY_MASK;
		k[6] = item.key6 & KEY_MASK;
		k[7] = item.key7 & KEY_MASK;
		distinct = 0;
		matched  = 1'b0;
		for (int i = 0; i < 8; i++) begin
			fresh = 1'b1;
			for (int j = 0; j < i; j++)
				if (k[j] == k[i]) fresh = 1'b0;
			if (fresh) distinct++;
			c[i] = 3'd0;
		end

		if (item.levels_equal || distinct == 8) begin
			for (int i = 0; i < 8; i++) c[i] = 3'(i);
			kind = item.levels_equal ? K_CUBE : K_HEX;
		end else if (distinct < 4) begin
			kind = K_DROP;
		end else begin
			kind = K_HEX;
			// whole face collapsed to one point: pyramid, tet, drop or error
			for (int f = 0; f < 6; f++) begin
				if (!matched && k[FACE_CORNERS[f][0]] == k[FACE_CORNERS[f][1]] &&
				    k[FACE_CORNERS[f][0]] == k[FACE_CORNERS[f][2]] &&
				    k[FACE_CORNERS[f][0]] == k[FACE_CORNERS[f][3]]) begin
					matched = 1'b1;
					b0   = FACE_CORNERS[f][4];
					b1   = FACE_CORNERS[f][5];
					b2   = FACE_CORNERS[f][6];
					b3   = FACE_CORNERS[f][7];
					apex = FACE_CORNERS[f][8];
					kind = K_ERR;
					if (distinct == 5) begin
						kind = K_PYR;
						c[0] = b0; c[1] = b1; c[2] = b2; c[3] = b3; c[4] = apex;
					end else if (distinct == 4) begin
						if (k[b0] == k[b1]) begin
							kind = K_TET;
							c[0] = b1; c[1] = b2; c[2] = b3; c[3] = apex;
						end else if (k[b1] == k[b2]) begin
							kind = K_TET;
							c[0] = b2; c[1] = b3; c[2] = b0; c[3] = apex;
						end else if (k[b2] == k[b3]) begin
							kind = K_TET;
							c[0] = b3; c[1] = b0; c[2] = b1; c[3] = apex;
						end else if (k[b3] == k[b0]) begin
							kind = K_TET;
							c[0] = b0; c[1] = b1; c[2] = b2; c[3] = apex;
						end else if (k[b0] == k[b2] || k[b1] == k[b3]) begin
							kind = K_DROP;
						end
					end
				end
			end
			// two opposite edges of a face collapsed: wedge
			for (int w = 0; w < 12; w++) begin
				if (!matched && k[EDGE_PAIRS[w][0]] == k[EDGE_PAIRS[w][1]] &&
				    k[EDGE_PAIRS[w][2]] == k[EDGE_PAIRS[w][3]]) begin
					matched = 1'b1;
					kind    = K_WEDGE;
					for (int j = 0; j < 6; j++) c[j] = EDGE_PAIRS[w][4 + j];
				end
			end
			if (!matched)
				for (int i = 0; i < 8; i++) c[i] = 3'(i);
		end

		if (kind == K_DROP || kind == K_ERR)
			for (int i = 0; i < 8; i++) c[i] = 3'd0;
		res.kind        = kind;
		res.out_corner0 = c[0];
		res.out_corner1 = c[1];
		res.out_corner2 = c[2];
		res.out_corner3 = c[3];
		res.out_corner4 = c[4];
		res.out_corner5 = c[5];
		res.out_corner6 = c[6];
		res.out_corner7 = c[7];
		res.out_level   = (kind == K_CUBE) ? item.cell_level : 5'd0;
		return res;
	endfunction

	function automatic int field_mismatch(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// Compare the oldest expected verdict first, then queue a new one on an input transfer
	always @(posedge clk) begin : scoreboard
		out_t want;
		if (arst_n) begin
			if (done) begin
				if (verdict_q.size() == 0) begin
					$error("result with no cell pending: kind %0d", verdict.kind);
					err_cnt++;
				end else begin
					want = verdict_q.pop_front();
					err_cnt += field_mismatch("kind", want.kind, verdict.kind);
					err_cnt += field_mismatch("out_corner0", want.out_corner0, verdict.out_corner0);
					err_cnt += field_mismatch("out_corner1", want.out_corner1, verdict.out_corner1);
					err_cnt += field_mismatch("out_corner2", want.out_corner2, verdict.out_corner2);
					err_cnt += field_mismatch("out_corner3", want.out_corner3, verdict.out_corner3);
					err_cnt += field_mismatch("out_corner4", want.out_corner4, verdict.out_corner4);
					err_cnt += field_mismatch("out_corner5", want.out_corner5, verdict.out_corner5);
					err_cnt += field_mismatch("out_corner6", want.out_corner6, verdict.out_corner6);
					err_cnt += field_mismatch("out_corner7", want.out_corner7, verdict.out_corner7);
					err_cnt += field_mismatch("out_level", want.out_level, verdict.out_level);
				end
			end
			if (start && !busy)
				verdict_q.insert(verdict_q.size(), predict_verdict(dual));
			pend = verdict_q.size();
		end
	end

	assign mismatches = err_cnt;
	assign awaiting   = pend;

endmodule

[tb/dual_cell_degeneracy_classifier_top_tb.sv]
// Testbench top for the dual cell classifier: clock, reset, cell stimulus and verdict.
`timescale 1ns / 1ps

module dual_cell_degeneracy_classifier_top_tb;
	import dccl_pkg::*;

	localparam int KEY_BITS     = 32;
	localparam int RANDOM_CELLS = 530;
	localparam int STALL_LIMIT  = 500;

	// How the base of a collapsed face is further degenerated
	typedef enum int {
		MERGE_NONE,
		MERGE_EDGE,
		MERGE_DIAG,
		MERGE_APEX
	} base_merge_e;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	in_t  dual   = '0;
	logic busy;
	logic done;
	out_t verdict;

	int mismatches;
	int awaiting;
	int quiet_cycles = 0;
	int corner_label [8];
	bit idle_on = 1'b1;

	always #1 clk = ~clk;

	dual_cell_degeneracy_classifier_top #(
		.KEY_BITS(KEY_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.dual(dual),
		.done(done),
		.verdict(verdict)
	);

	dccl_verdict_checker #(
		.KEY_BITS(KEY_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.dual(dual),
		.done(done),
		.verdict(verdict),
		.mismatches(mismatches),
		.awaiting(awaiting)
	);

	// Watchdog: too long without any transfer on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// VTK corner index of the cube corner with coordinate axis at side, others from p
	function automatic int corner_on(int axis, bit side, bit [1:0] p);
		bit [2:0] xyz;
		xyz[axis]           = side;
		xyz[(axis + 1) % 3] = p[0];
		xyz[(axis + 2) % 3] = p[1];
		return xyz[2] * 4 + (xyz[1] ? (xyz[0] ? 2 : 3) : (xyz[0] ? 1 : 0));
	endfunction

	task automatic label_distinct();
		for (int i = 0; i < 8; i++) corner_label[i] = i;
	endtask

	// Collapse one face to a point, optionally degenerate the opposite face
	task automatic collapse_face(int axis, bit side, base_merge_e merge);
		bit [1:0] p;
		bit [1:0] q;
		for (int i = 0; i < 4; i++)
			corner_label[corner_on(axis, side, 2'(i))] = corner_label[corner_on(axis, side, 2'd0)];
		p = 2'($urandom_range(0, 3));
		q = p ^ 2'b11;
		if (merge == MERGE_EDGE)
			q = p ^ ($urandom_range(0, 1) ? 2'b01 : 2'b10);
		if (merge == MERGE_EDGE || merge == MERGE_DIAG)
			corner_label[corner_on(axis, !side, q)] = corner_label[corner_on(axis, !side, p)];
		else if (merge == MERGE_APEX)
			corner_label[corner_on(axis, !side, p)] = corner_label[corner_on(axis, side, 2'd0)];
	endtask

	// Collapse the edges e1 and e2 running along axis
	task automatic collapse_edges(int axis, bit [1:0] e1, bit [1:0] e2);
		corner_label[corner_on(axis, 1'b1, e1)] = corner_label[corner_on(axis, 1'b0, e1)];
		corner_label[corner_on(axis, 1'b1, e2)] = corner_label[corner_on(axis, 1'b0, e2)];
	endtask

	task automatic merge_random_pair();
		corner_label[$urandom_range(0, 7)] = corner_label[$urandom_range(0, 7)];
	endtask

	// One input transfer, after a random gap when idling is on
	task automatic drive_cell(in_t item);
		int gap;
		gap = idle_on ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		dual  = item;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// Turn corner labels into keys; sometimes keys that each differ from one base in a single bit
	task automatic send_labels(bit lev, logic [4:0] level);
		logic [31:0] sym [8];
		logic [31:0] base;
		bit          near;
		in_t         item;
		near = ($urandom_range(0, 3) == 0);
		base = $urandom();
		for (int i = 0; i < 8; i++)
			sym[i] = near ? base ^ (32'h1 << $urandom_range(0, 31)) : $urandom();
		item.key0         = sym[corner_label[0]];
		item.key1         = sym[corner_label[1]];
		item.key2         = sym[corner_label[2]];
		item.key3         = sym[corner_label[3]];
		item.key4         = sym[corner_label[4]];
		item.key5         = sym[corner_label[5]];
		item.key6         = sym[corner_label[6]];
		item.key7         = sym[corner_label[7]];
		item.levels_equal = lev;
		item.cell_level   = level;
		drive_cell(item);
	endtask

	// Mostly well-formed collapsed faces and edge pairs, the rest noise
	task automatic random_cell();
		int       pick;
		int       alphabet;
		bit       lev;
		bit [1:0] e1;
		bit [1:0] e2;
		pick = $urandom_range(0, 99);
		lev  = ($urandom_range(0, 24) == 0);
		label_distinct();
		if (pick < 8) begin
			// all corners distinct
		end else if (pick < 20) begin
			alphabet = $urandom_range(1, 8);
			for (int i = 0; i < 8; i++) corner_label[i] = $urandom_range(0, alphabet - 1);
		end else if (pick < 55) begin
			collapse_face($urandom_range(0, 2), $urandom_range(0, 1),
				base_merge_e'($urandom_range(0, 3)));
			if ($urandom_range(0, 3) == 0) merge_random_pair();
		end else if (pick < 85) begin
			e1 = 2'($urandom_range(0, 3));
			e2 = ($urandom_range(0, 4) == 0) ? e1 ^ 2'b11 : e1 ^ 2'($urandom_range(1, 2));
			collapse_edges($urandom_range(0, 2), e1, e2);
			if ($urandom_range(0, 4) == 0) merge_random_pair();
		end else if (pick < 95) begin
			merge_random_pair();
			merge_random_pair();
		end else begin
			lev = 1'b1;
			for (int i = 0; i < 8; i++) corner_label[i] = $urandom_range(0, 7);
		end
		send_labels(lev, 5'($urandom_range(0, 31)));
	endtask

	initial begin : stimulus
		in_t item;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extreme keys and levels
		item = '0;
		drive_cell(item);
		item = '1;
		drive_cell(item);
		item.levels_equal = 1'b0;
		drive_cell(item);
		label_distinct();
		send_labels(1'b1, 5'd0);
		send_labels(1'b0, 5'd31);

		// Directed: each face collapsed into a pyramid apex
		for (int a = 0; a < 3; a++) begin
			for (int s = 0; s < 2; s++) begin
				label_distinct();
				collapse_face(a, s[0], MERGE_NONE);
				send_labels(1'b0, 5'($urandom_range(0, 31)));
			end
		end

		// Directed: tet, diagonal drop, apex merge error
		label_distinct();
		collapse_face(2, 1'b0, MERGE_EDGE);
		send_labels(1'b0, 5'd7);
		label_distinct();
		collapse_face(0, 1'b1, MERGE_DIAG);
		send_labels(1'b0, 5'd7);
		label_distinct();
		collapse_face(1, 1'b0, MERGE_APEX);
		send_labels(1'b0, 5'd7);

		// Directed: wedges, body diagonal fallback hex, too few distinct keys
		label_distinct();
		collapse_edges(0, 2'b00, 2'b10);
		send_labels(1'b0, 5'd3);
		label_distinct();
		collapse_edges(2, 2'b01, 2'b11);
		send_labels(1'b0, 5'd3);
		label_distinct();
		corner_label[6] = corner_label[0];
		send_labels(1'b0, 5'd3);
		for (int i = 0; i < 8; i++) corner_label[i] = i % 3;
		send_labels(1'b0, 5'd3);

		// Random part, with a stretch of back-to-back transfers and one full drain
		for (int n = 0; n < RANDOM_CELLS; n++) begin
			if (n == 0)
				idle_on = 1'b0;
			else if (n == 40)
				idle_on = 1'b1;
			else if (n > 40 && $urandom_range(0, 39) == 0)
				idle_on = !idle_on;
			if (n == RANDOM_CELLS / 2) begin
				start = 1'b0;
				while (awaiting != 0) @(negedge clk);
				repeat ($urandom_range(1, 13)) @(negedge clk);
			end
			random_cell();
		end
		start = 1'b0;

		// Let the pipeline empty
		while (awaiting != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatches == 0 && awaiting == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
